// ----- sv/mcs_pkg.sv -----
// ----------------------------------------------------------------------------
// mcs_pkg: motor command sequencer shared types and constants
// Command codes, reply codes, motor states and the transaction structs that
// pass between the decode logic, the result buffer and the top level.
// ----------------------------------------------------------------------------
package mcs_pkg;

  // Command codes
  localparam logic [4:0] CMD_CONNECT       = 5'd0;
  localparam logic [4:0] CMD_DISCONNECT    = 5'd1;
  localparam logic [4:0] CMD_SET_DIG_OUT   = 5'd2;
  localparam logic [4:0] CMD_GET_DIG_IN    = 5'd3;
  localparam logic [4:0] CMD_GET_ANALOG    = 5'd4;
  localparam logic [4:0] CMD_SET_CTRL_PARA = 5'd5;
  localparam logic [4:0] CMD_GET_CTRL_PARA = 5'd6;
  localparam logic [4:0] CMD_GET_POS_VEL   = 5'd7;
  localparam logic [4:0] CMD_GET_STATUS    = 5'd8;
  localparam logic [4:0] CMD_BRAKE         = 5'd9;
  localparam logic [4:0] CMD_ENABLE_MOTOR  = 5'd10;
  localparam logic [4:0] CMD_SYNC          = 5'd11;
  localparam logic [4:0] CMD_ENABLE_COMM   = 5'd12;
  localparam logic [4:0] CMD_SET_CMD_VAL   = 5'd13;
  localparam logic [4:0] CMD_SET_MOTION    = 5'd14;
  localparam logic [4:0] CMD_EM_STOP       = 5'd15;
  localparam logic [4:0] CMD_RESET_EM_STOP = 5'd16;

  // Reply status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOTACC = 2'd1;
  localparam logic [1:0] ST_ERROR  = 2'd2;

  // Attached data kinds
  localparam logic [2:0] DK_NONE    = 3'd0;
  localparam logic [2:0] DK_DIG_IN  = 3'd1;
  localparam logic [2:0] DK_ANALOG  = 3'd2;
  localparam logic [2:0] DK_DEBUG   = 3'd3;
  localparam logic [2:0] DK_POS_VEL = 3'd4;
  localparam logic [2:0] DK_STATUS  = 3'd5;
  localparam logic [2:0] DK_SYNC    = 3'd6;

  // On/off argument values
  localparam logic [7:0] ARG_OFF = 8'd0;
  localparam logic [7:0] ARG_ON  = 8'd1;

  // Sync acceptance window, exclusive on both ends
  localparam logic signed [8:0] SYNC_LO = -9'sd30;
  localparam logic signed [8:0] SYNC_HI = 9'sd90;

  typedef enum logic [5:0] {
    MS_BRAKE_CLOSED = 6'b000001,
    MS_BRAKE_OPEN   = 6'b000010,
    MS_ENABLED      = 6'b000100,
    MS_SYNCH        = 6'b001000,
    MS_RUNNING      = 6'b010000,
    MS_EMSTOP       = 6'b100000
  } mstate_e;

  typedef struct packed {
    logic [4:0] func;
    logic [1:0] source;
    logic       from_internal;
    logic [7:0] arg;
    logic [8:0] sync_measured;
  } in_t;

  typedef struct packed {
    logic       send_reply;
    logic [4:0] reply_cmd;
    logic [1:0] reply_status;
    logic [2:0] data_kind;
    logic [1:0] destination;
    logic       brake_released;
    logic       motor_on;
    logic       posvel_run;
    logic       comm_run;
    logic       sync_run;
    logic       restart_request;
    logic       last;
  } out_t;

  typedef struct packed {
    logic brake;
    logic motor;
    logic posvel;
    logic comm;
    logic sync;
  } flags_t;

  typedef struct packed {
    logic    connected;
    mstate_e mstate;
    flags_t  flags;
  } ctl_t;

  // Results of one input transaction, handed to the result buffer
  typedef struct packed {
    logic [1:0] cnt;
    out_t       r0;
    out_t       r1;
  } batch_t;

  localparam ctl_t CTL_RESET = '{connected: 1'b0, mstate: MS_BRAKE_CLOSED, flags: '0};

endpackage

// ----- sv/mcs_step.sv -----
// ----------------------------------------------------------------------------
// mcs_step: command decode and state transition
// Given the registered command and the current control state, computes the
// next control state and the zero to two result transactions.
// ----------------------------------------------------------------------------
module mcs_step (
  input  mcs_pkg::in_t   item_i,
  input  mcs_pkg::ctl_t  ctl_i,
  input  logic [8:0]     sync_ref_i,
  output mcs_pkg::ctl_t  ctl_o,
  output mcs_pkg::batch_t batch_o
);
  import mcs_pkg::*;

  logic              rep_en;
  logic              rep_send;
  logic [4:0]        rep_cmd;
  logic [1:0]        rep_status;
  logic [2:0]        rep_kind;
  logic              rep_restart;
  logic              dual;
  logic              reject;
  logic [8:0]        diff;
  logic              sync_ok;
  flags_t            rflags;
  out_t              res0;
  out_t              res1;

  // Wrap the position error into -256..255 and check the window
  assign diff    = item_i.sync_measured - sync_ref_i;
  assign sync_ok = ($signed(diff) > SYNC_LO) && ($signed(diff) < SYNC_HI);

  // Decode the command against connection and motor state
  always_comb begin
    ctl_o       = ctl_i;
    rep_en      = 1'b0;
    rep_send    = 1'b1;
    rep_cmd     = item_i.func;
    rep_status  = ST_OK;
    rep_kind    = DK_NONE;
    rep_restart = 1'b0;
    dual        = 1'b0;
    reject      = 1'b0;

    if (item_i.func == CMD_DISCONNECT) begin
      rep_en      = 1'b1;
      rep_send    = 1'b0;
      rep_cmd     = CMD_CONNECT;
      rep_restart = 1'b1;
      ctl_o       = CTL_RESET;
    end else if (!ctl_i.connected) begin
      if (item_i.func == CMD_CONNECT) begin
        rep_en          = 1'b1;
        ctl_o.connected = 1'b1;
      end else begin
        reject = 1'b1;
      end
    end else begin
      case (item_i.func)
        CMD_SET_DIG_OUT, CMD_SET_CTRL_PARA: begin
        end
        CMD_GET_DIG_IN: begin
          rep_en   = 1'b1;
          rep_kind = DK_DIG_IN;
        end
        CMD_GET_ANALOG: begin
          rep_en   = 1'b1;
          rep_kind = DK_ANALOG;
        end
        CMD_GET_CTRL_PARA: begin
          rep_en   = 1'b1;
          rep_kind = DK_DEBUG;
        end
        CMD_GET_POS_VEL: begin
          rep_en   = 1'b1;
          rep_kind = DK_POS_VEL;
        end
        CMD_GET_STATUS: begin
          rep_en   = 1'b1;
          rep_kind = DK_STATUS;
        end
        default: begin
          case (ctl_i.mstate)
            MS_BRAKE_CLOSED: begin
              if (item_i.func == CMD_BRAKE) begin
                if (item_i.arg == ARG_ON) begin
                  ctl_o.flags.brake = 1'b1;
                  ctl_o.mstate      = MS_BRAKE_OPEN;
                  rep_en            = 1'b1;
                end
              end else begin
                reject = 1'b1;
              end
            end
            MS_BRAKE_OPEN: begin
              if (item_i.func == CMD_BRAKE) begin
                if (item_i.arg == ARG_OFF) begin
                  ctl_o.flags.brake = 1'b0;
                  ctl_o.mstate      = MS_BRAKE_CLOSED;
                  rep_en            = 1'b1;
                end
              end else if (item_i.func == CMD_ENABLE_MOTOR) begin
                if (item_i.arg == ARG_ON) begin
                  ctl_o.flags.motor  = 1'b1;
                  ctl_o.flags.posvel = 1'b0;
                  ctl_o.flags.comm   = 1'b0;
                  ctl_o.flags.sync   = 1'b1;
                  ctl_o.mstate       = MS_ENABLED;
                  rep_en             = 1'b1;
                end
              end else begin
                reject = 1'b1;
              end
            end
            MS_ENABLED: begin
              if (item_i.func == CMD_ENABLE_MOTOR) begin
                if (item_i.arg == ARG_OFF) begin
                  ctl_o.flags.motor  = 1'b0;
                  ctl_o.flags.posvel = 1'b0;
                  ctl_o.flags.comm   = 1'b0;
                  ctl_o.flags.sync   = 1'b0;
                  ctl_o.mstate       = MS_BRAKE_OPEN;
                  rep_en             = 1'b1;
                end
              end else if (item_i.func == CMD_SYNC) begin
                rep_en   = 1'b1;
                rep_kind = DK_SYNC;
                if (sync_ok) begin
                  ctl_o.mstate = MS_SYNCH;
                end else begin
                  ctl_o.flags.motor  = 1'b0;
                  ctl_o.flags.posvel = 1'b0;
                  ctl_o.flags.comm   = 1'b0;
                  ctl_o.flags.sync   = 1'b0;
                  ctl_o.mstate       = MS_BRAKE_OPEN;
                  rep_status         = ST_ERROR;
                end
              end else begin
                reject = 1'b1;
              end
            end
            MS_SYNCH: begin
              if (item_i.func == CMD_ENABLE_COMM) begin
                ctl_o.flags.sync   = 1'b0;
                ctl_o.flags.comm   = 1'b1;
                ctl_o.flags.posvel = 1'b1;
                ctl_o.mstate       = MS_RUNNING;
                rep_en             = 1'b1;
              end else begin
                reject = 1'b1;
              end
            end
            MS_RUNNING, MS_EMSTOP: begin
              if (item_i.func == CMD_SET_CMD_VAL) begin
                rep_en     = 1'b1;
                dual       = 1'b1;
                rep_cmd    = CMD_GET_STATUS;
                rep_kind   = DK_STATUS;
              end else if (item_i.func == CMD_ENABLE_MOTOR) begin
                if (item_i.arg == ARG_OFF) begin
                  ctl_o.flags.motor  = 1'b0;
                  ctl_o.flags.posvel = 1'b0;
                  ctl_o.flags.comm   = 1'b0;
                  ctl_o.flags.sync   = 1'b0;
                  ctl_o.mstate       = MS_BRAKE_OPEN;
                  rep_en             = 1'b1;
                end
              end else if (ctl_i.mstate == MS_RUNNING && item_i.func == CMD_SET_MOTION) begin
                rep_en = 1'b1;
              end else if (ctl_i.mstate == MS_RUNNING && item_i.func == CMD_EM_STOP) begin
                ctl_o.flags.posvel = 1'b0;
                ctl_o.flags.brake  = 1'b0;
                ctl_o.mstate       = MS_EMSTOP;
                rep_en             = !item_i.from_internal;
              end else if (ctl_i.mstate == MS_EMSTOP &&
                           item_i.func == CMD_RESET_EM_STOP) begin
                ctl_o.flags.brake  = 1'b1;
                ctl_o.flags.posvel = 1'b1;
                ctl_o.mstate       = MS_RUNNING;
                rep_en             = 1'b1;
              end else begin
                reject = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      endcase
    end

    // Refuse external events; drop internal ones silently
    if (reject && !item_i.from_internal) begin
      rep_en     = 1'b1;
      rep_status = ST_NOTACC;
    end
  end

  // Restart result shows the flags from before the clear
  assign rflags = rep_restart ? ctl_i.flags : ctl_o.flags;

  // Assemble the result transactions
  always_comb begin
    res0.send_reply      = rep_send;
    res0.reply_cmd       = rep_cmd;
    res0.reply_status    = rep_status;
    res0.data_kind       = rep_kind;
    res0.destination     = item_i.source;
    res0.brake_released  = rflags.brake;
    res0.motor_on        = rflags.motor;
    res0.posvel_run      = rflags.posvel;
    res0.comm_run        = rflags.comm;
    res0.sync_run        = rflags.sync;
    res0.restart_request = rep_restart;
    res0.last            = !dual;

    res1              = res0;
    res1.reply_cmd    = CMD_GET_POS_VEL;
    res1.reply_status = ST_OK;
    res1.data_kind    = DK_POS_VEL;
    res1.last         = 1'b1;
  end

  assign batch_o.cnt = dual ? 2'd2 : {1'b0, rep_en};
  assign batch_o.r0  = res0;
  assign batch_o.r1  = res1;

endmodule

// ----- sv/mcs_resq.sv -----
// ----------------------------------------------------------------------------
// mcs_resq: two-slot result buffer
// Holds the results of one command and hands them out one per cycle while the
// output is not stalled; takes the next batch in the cycle that its last held result leaves.
// ----------------------------------------------------------------------------
module mcs_resq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mcs_pkg::batch_t batch_i,
  output logic            free_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output mcs_pkg::out_t   out_data_o
);
  import mcs_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  out_t       slot0_q, slot0_d;
  out_t       slot1_q, slot1_d;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = slot0_q;
  assign pop         = out_valid_o && !out_stall_i;
  assign free_o      = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);

  // Load a new batch, or advance the second slot on a pop
  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (push_i) begin
      cnt_d   = batch_i.cnt;
      slot0_d = batch_i.r0;
      slot1_d = batch_i.r1;
    end else if (pop) begin
      cnt_d   = cnt_q - 2'd1;
      slot0_d = slot1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  // Never load over a result that is still waiting
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> free_o) else $error("result buffer loaded while busy");

  // First of a pair is never marked last; a single one always is
  a_last_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last == (cnt_q == 2'd1)))
    else $error("last flag out of step with buffer fill");

  // Popping the first of a pair brings up the second
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && cnt_q == 2'd2) |=> (cnt_q == 2'd1 && out_data_o == $past(slot1_q)))
    else $error("second result not advanced");

endmodule

// ----- sv/motor_command_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// motor_command_sequencer_unit: motor command sequencer
// The input transaction is held in the input register, decoded, and its
// results are registered in the result buffer. Throughput: one command per
// cycle unless stalled; a two-result command holds back the next one, set by the single result port.
// Reset clears connection, motor state, flags and sync reference at once.
// ----------------------------------------------------------------------------
module motor_command_sequencer_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mcs_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mcs_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [8:0]    cfg_wdata_i
);
  import mcs_pkg::*;

  in_t        in_q;
  logic       in_vld_q;
  ctl_t       ctl_q, ctl_d;
  logic [8:0] sync_ref_q;
  batch_t     batch;
  logic       resq_free;
  logic       move;
  logic       accept;

  assign move       = in_vld_q && resq_free;
  assign in_stall_o = in_vld_q && !resq_free;
  assign accept     = in_valid_i && !in_stall_o;

  // Decode the held command
  mcs_step u_step (
    .item_i     (in_q),
    .ctl_i      (ctl_q),
    .sync_ref_i (sync_ref_q),
    .ctl_o      (ctl_d),
    .batch_o    (batch)
  );

  // Queue its results
  mcs_resq u_resq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (move),
    .batch_i     (batch),
    .free_o      (resq_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Input register valid, control state and sync reference
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      ctl_q      <= CTL_RESET;
      sync_ref_q <= '0;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (move) begin
        in_vld_q <= 1'b0;
      end
      if (move) begin
        ctl_q <= ctl_d;
      end
      if (cfg_we_i) begin
        sync_ref_q <= cfg_wdata_i;
      end
    end
  end

  // Capture the input transaction payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

endmodule
